// ===== sv/tdq_pkg.sv =====
// Shared types and codes for the task run-queue deque.
package tdq_pkg;

   localparam int KIND_W   = 2;
   localparam int TASK_W   = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;
   localparam int SLOT_W   = 2 * TASK_W;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_PUSH_TAIL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_HEAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POP       = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TASK_W-1:0] task_entry;
      logic [TASK_W-1:0] task_arg;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TASK_W-1:0]   popped_entry;
      logic [TASK_W-1:0]   popped_arg;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // Side information that travels alongside the slot read
   typedef struct packed {
      logic                pop_ok;
      logic [STATUS_W-1:0] status;
      logic [OCC_W-1:0]    occupancy;
   } meta_type;

endpackage

// ===== sv/tdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/tdq_ctrl.sv =====
// Head/count pointer logic, capacity register and slot store access.
module tdq_ctrl
   import tdq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   input  logic                csr_valid,
   input  logic [OCC_W-1:0]    csr_data,
   input  logic                a_take,
   output logic                a_valid,
   output meta_type            a_meta,
   output logic [SLOT_W-1:0]   a_slot
);

   localparam int IDX_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int SUM_W = (IDX_W > OCC_W ? IDX_W : OCC_W) + 1;
   localparam logic [OCC_W-1:0] CAP_RESET = OCC_W'(DEPTH < 16 ? DEPTH : 16);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [OCC_W-1:0] count_ff, count_in;
   logic [OCC_W-1:0] cap_ff, cap_in;
   logic             a_valid_ff;
   meta_type         meta_ff, meta_in;

   logic             accept;
   logic             we;
   logic [IDX_W-1:0] waddr;
   logic [SUM_W-1:0] cap_x, tail_sum, tail_wrap, head_inc, cap_m1, csr_x;

   assign req_ready = !a_valid_ff || a_take;
   assign accept    = req_valid && req_ready;

   assign cap_x     = SUM_W'(cap_ff);
   assign cap_m1    = cap_x - SUM_W'(1);
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_wrap = tail_sum - cap_x;
   assign head_inc  = SUM_W'(head_ff) + SUM_W'(1);
   assign csr_x     = SUM_W'(csr_data);

   always_comb begin
      head_in          = head_ff;
      count_in         = count_ff;
      we               = 1'b0;
      waddr            = head_ff;
      meta_in.pop_ok   = 1'b0;
      meta_in.status   = STATUS_OK;
      case (req_data.kind)
         KIND_PUSH_TAIL: begin
            if (count_ff == cap_ff) begin
               meta_in.status = STATUS_FULL;
            end else begin
               we       = 1'b1;
               waddr    = (tail_sum >= cap_x) ? tail_wrap[IDX_W-1:0] : tail_sum[IDX_W-1:0];
               count_in = count_ff + OCC_W'(1);
            end
         end
         KIND_PUSH_HEAD: begin
            if (count_ff == cap_ff) begin
               meta_in.status = STATUS_FULL;
            end else begin
               we       = 1'b1;
               head_in  = (head_ff == '0) ? cap_m1[IDX_W-1:0] : head_ff - IDX_W'(1);
               waddr    = head_in;
               count_in = count_ff + OCC_W'(1);
            end
         end
         KIND_POP: begin
            if (count_ff == '0) begin
               meta_in.status = STATUS_EMPTY;
            end else begin
               meta_in.pop_ok = 1'b1;
               head_in  = (head_inc >= cap_x) ? '0 : head_inc[IDX_W-1:0];
               count_in = count_ff - OCC_W'(1);
            end
         end
         default: begin
         end
      endcase
      meta_in.occupancy = count_in;
   end

   // Clamp the written capacity into 1..DEPTH once, at write time
   always_comb begin
      if (csr_data == '0) begin
         cap_in = OCC_W'(1);
      end else if (csr_x > SUM_W'(DEPTH)) begin
         cap_in = OCC_W'(DEPTH);
      end else begin
         cap_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         cap_ff     <= CAP_RESET;
         a_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff   <= cap_in;
            head_ff  <= '0;
            count_ff <= '0;
         end else if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (a_take) begin
            a_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff <= meta_in;
      end
   end

   tdq_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock (clock),
      .we    (accept && we),
      .waddr (waddr),
      .wdata ({req_data.task_arg, req_data.task_entry}),
      .re    (accept),
      .raddr (head_ff),
      .rdata (a_slot)
   );

   assign a_valid = a_valid_ff;
   assign a_meta  = meta_ff;

endmodule

// ===== sv/tdq_out.sv =====
// Result register: forms the response and holds it until the transfer.
module tdq_out
   import tdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              a_valid,
   input  meta_type          a_meta,
   input  logic [SLOT_W-1:0] a_slot,
   output logic              a_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   assign a_take = a_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_data_in.status       = a_meta.status;
      rsp_data_in.popped_entry = a_meta.pop_ok ? a_slot[TASK_W-1:0] : '0;
      rsp_data_in.popped_arg   = a_meta.pop_ok ? a_slot[SLOT_W-1:TASK_W] : '0;
      rsp_data_in.occupancy    = a_meta.occupancy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/task_deque_run_queue_top.sv =====
// Top level of the task run-queue deque (push tail, push head, pop head).
// Response path: a request passes through stage A (status and registered slot
// read) and then the output register before its response is offered.
// Throughput: one item per cycle while rsp_ready does not stall the output; each
// item updates the pointers once and reads one slot, and a push also writes one.
// Reset: queue empty (head 0, count 0), capacity min(16, DEPTH); the slot store
// is not cleared, since only slots filled since the last reset are ever popped.
module task_deque_run_queue_top
   import tdq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [OCC_W-1:0] csr_data
);

   // Stage A carries the registered slot read plus status and occupancy;
   // the output stage parts it from the response side, so a new request
   // transfer can be taken into a free stage A while a finished response still waits.
   logic              a_valid;
   logic              a_take;
   meta_type          a_meta;
   logic [SLOT_W-1:0] a_slot;

   // Users must write capacity only while idle; not enforced, taken at once.
   assign csr_ready = 1'b1;

   // Advance head and count; read the head slot per transfer, write one on a push.
   tdq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .a_take    (a_take),
      .a_valid   (a_valid),
      .a_meta    (a_meta),
      .a_slot    (a_slot)
   );

   // Hold the response until its transfer; drop popped fields on errors.
   tdq_out u_out (
      .clock     (clock),
      .reset     (reset),
      .a_valid   (a_valid),
      .a_meta    (a_meta),
      .a_slot    (a_slot),
      .a_take    (a_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
